@@ hw/rtl/rovc_pkg.sv @@
package rovc_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REFUSED   = 3'd2,
      ST_HIT       = 3'd3,
      ST_MISS      = 3'd4,
      ST_CLEARED   = 3'd5,
      ST_EMPTY     = 3'd6,
      ST_UNUSED    = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_EXEC  = 2'd1,
      FSM_CLEAR = 2'd2,
      FSM_SPARE = 2'd3
   } fsm_type;

   typedef enum logic [1:0] {
      OP_REPLY = 2'd0,
      OP_INS   = 2'd1,
      OP_EVICT = 2'd2,
      OP_HIT   = 2'd3
   } op_type;

   localparam int FIELD_HANDLE_BITS = 32;
   localparam int FIELD_KEY_BITS    = 64;
   localparam int CFG_BITS          = 5;

endpackage

@@ hw/rtl/rovc_if.sv @@
interface rovc_req_if
   import rovc_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   func;
   logic [FIELD_KEY_BITS-1:0]    key;
   logic [FIELD_HANDLE_BITS-1:0] handle;
   modport source (output valid, func, key, handle, input ready);
   modport sink (input valid, func, key, handle, output ready);
endinterface

interface rovc_rsp_if
   import rovc_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [2:0]                   status;
   logic [FIELD_HANDLE_BITS-1:0] found_handle;
   logic                         evicted;
   logic [FIELD_HANDLE_BITS-1:0] evicted_handle;
   logic                         last;
   modport source (output valid, status, found_handle, evicted, evicted_handle, last,
                   input ready);
   modport sink (input valid, status, found_handle, evicted, evicted_handle, last,
                 output ready);
endinterface

interface rovc_csr_if
   import rovc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/released_object_victim_cache_unit.sv @@
// channel   | dir | beat
// req_bus   | in  | func, key, handle
// rsp_bus   | out | status, found_handle, evicted, evicted_handle, last
// csr_bus   | in  | capacity
// Insert and lookup run as tag match and link read, then link write-back.
// Clear returns one rsp beat per stored entry, chained through the next-link memory.
// Reset empties the store and sets capacity to min(CAPACITY, 16); no clearing pass is needed.
// A stalled rsp beat holds the block in its write-back or clear step.
module released_object_victim_cache_unit
   import rovc_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int KEY_BITS    = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   rovc_req_if.sink   req_bus,
   rovc_rsp_if.source rsp_bus,
   rovc_csr_if.sink   csr_bus
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CAP_RST = (CAPACITY < 16) ? CAPACITY : 16;

   fsm_type state_ff, state_in;

   logic [KEY_BITS-1:0]    key_ff [CAPACITY];
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [SW-1:0]          next_mem [CAPACITY];
   logic [SW-1:0]          prev_mem [CAPACITY];
   logic [HANDLE_BITS-1:0] hnd_mem [CAPACITY];
   logic [SW-1:0]          nrd_ff, prd_ff;
   logic [HANDLE_BITS-1:0] hrd_ff;

   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in, cap_ff, cap_in;

   op_type                 op_ff, op_in;
   status_type             stat_ff, stat_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [KEY_BITS-1:0]    kh_ff;
   logic [HANDLE_BITS-1:0] hh_ff;

   logic                         rsp_valid_ff, rsp_valid_in, rsp_load;
   status_type                   rsp_stat_ff, rsp_stat_in;
   logic [FIELD_HANDLE_BITS-1:0] rsp_fh_ff, rsp_fh_in, rsp_eh_ff, rsp_eh_in;
   logic                         rsp_ev_ff, rsp_ev_in, rsp_last_ff, rsp_last_in;

   logic                rd_en, n_we, p_we, e_we, out_free, accept, cfg_wr;
   logic [SW-1:0]       rd_addr, n_wa, n_wd, p_wa, p_wd;
   logic [KEY_BITS-1:0] rkey;
   logic [CAPACITY-1:0] hit_vec;
   logic                hit, any_free, key_zero;
   logic [SW-1:0]       hit_idx, free_idx;

   assign req_bus.ready = (state_ff == FSM_IDLE);
   assign csr_bus.ready = (state_ff == FSM_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign cfg_wr = csr_bus.valid && csr_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign rkey = KEY_BITS'(req_bus.key);
   assign key_zero = (rkey == '0);

   always_comb begin
      hit_idx = '0;
      free_idx = '0;
      any_free = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == rkey);
         if (hit_vec[i]) hit_idx = SW'(i);
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SW'(i);
            any_free = 1'b1;
         end
      end
      hit = (|hit_vec) && !key_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      stat_in = stat_ff;
      slot_in = slot_ff;
      rd_en = 1'b0;
      rd_addr = head_ff;
      cur_in = cur_ff;
      n_we = 1'b0; n_wa = tail_ff; n_wd = slot_ff;
      p_we = 1'b0; p_wa = slot_ff; p_wd = tail_ff;
      e_we = 1'b0;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      cap_in = cap_ff;
      rsp_load = 1'b0;
      rsp_stat_in = rsp_stat_ff;
      rsp_fh_in = '0;
      rsp_ev_in = 1'b0;
      rsp_eh_in = '0;
      rsp_last_in = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            if (cfg_wr) begin
               cap_in = (int'(csr_bus.data) > CAPACITY) ? CW'(CAPACITY) : CW'(csr_bus.data);
               valid_in = '0;
               count_in = '0;
            end
            if (accept) begin
               op_in = OP_REPLY;
               state_in = FSM_EXEC;
               case (func_type'(req_bus.func))
                  FUNC_INSERT: begin
                     if (key_zero || cap_ff == '0) begin
                        stat_in = ST_REFUSED;
                     end else if (hit) begin
                        stat_in = ST_DUPLICATE;
                     end else if (count_ff >= cap_ff || !any_free) begin
                        op_in = OP_EVICT;
                        slot_in = head_ff;
                        rd_en = 1'b1;
                        rd_addr = head_ff;
                     end else begin
                        op_in = OP_INS;
                        slot_in = free_idx;
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (hit) begin
                        op_in = OP_HIT;
                        slot_in = hit_idx;
                        rd_en = 1'b1;
                        rd_addr = hit_idx;
                     end else begin
                        stat_in = ST_MISS;
                     end
                  end
                  FUNC_CLEAR: begin
                     if (count_ff == '0) begin
                        stat_in = ST_EMPTY;
                     end else begin
                        state_in = FSM_CLEAR;
                        rd_en = 1'b1;
                        rd_addr = head_ff;
                        cur_in = head_ff;
                     end
                  end
                  default: state_in = FSM_IDLE;
               endcase
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in = FSM_IDLE;
               rsp_load = 1'b1;
               case (op_ff)
                  OP_REPLY: rsp_stat_in = stat_ff;
                  OP_INS: begin
                     rsp_stat_in = ST_INSERTED;
                     e_we = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     count_in = count_ff + CW'(1);
                     tail_in = slot_ff;
                     if (count_ff == '0) begin
                        head_in = slot_ff;
                     end else begin
                        n_we = 1'b1;
                        p_we = 1'b1;
                     end
                  end
                  OP_EVICT: begin
                     rsp_stat_in = ST_INSERTED;
                     rsp_ev_in = 1'b1;
                     rsp_eh_in = FIELD_HANDLE_BITS'(hrd_ff);
                     e_we = 1'b1;
                     if (head_ff != tail_ff) begin
                        head_in = nrd_ff;
                        tail_in = slot_ff;
                        n_we = 1'b1;
                        p_we = 1'b1;
                     end
                  end
                  OP_HIT: begin
                     rsp_stat_in = ST_HIT;
                     rsp_fh_in = FIELD_HANDLE_BITS'(hrd_ff);
                     valid_in[slot_ff] = 1'b0;
                     count_in = count_ff - CW'(1);
                     if (slot_ff == head_ff) begin
                        head_in = nrd_ff;
                     end else begin
                        n_we = 1'b1;
                        n_wa = prd_ff;
                        n_wd = nrd_ff;
                     end
                     if (slot_ff == tail_ff) begin
                        tail_in = prd_ff;
                     end else begin
                        p_we = 1'b1;
                        p_wa = nrd_ff;
                        p_wd = prd_ff;
                     end
                  end
                  default: rsp_stat_in = stat_ff;
               endcase
            end
         end
         FSM_CLEAR: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_stat_in = ST_CLEARED;
               rsp_fh_in = FIELD_HANDLE_BITS'(hrd_ff);
               rsp_last_in = (cur_ff == tail_ff);
               if (cur_ff == tail_ff) begin
                  state_in = FSM_IDLE;
                  valid_in = '0;
                  count_in = '0;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = nrd_ff;
                  cur_in = nrd_ff;
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         cap_ff <= CW'(CAP_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         cap_ff <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      cur_ff <= cur_in;
      op_ff <= op_in;
      stat_ff <= stat_in;
      slot_ff <= slot_in;
      if (accept) begin
         kh_ff <= rkey;
         hh_ff <= HANDLE_BITS'(req_bus.handle);
      end
      if (e_we) key_ff[slot_ff] <= kh_ff;
      if (rsp_load) begin
         rsp_stat_ff <= rsp_stat_in;
         rsp_fh_ff <= rsp_fh_in;
         rsp_ev_ff <= rsp_ev_in;
         rsp_eh_ff <= rsp_eh_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         nrd_ff <= next_mem[rd_addr];
         prd_ff <= prev_mem[rd_addr];
         hrd_ff <= hnd_mem[rd_addr];
      end
      if (n_we) next_mem[n_wa] <= n_wd;
      if (p_we) prev_mem[p_wa] <= p_wd;
      if (e_we) hnd_mem[slot_ff] <= hh_ff;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = rsp_stat_ff;
   assign rsp_bus.found_handle = rsp_fh_ff;
   assign rsp_bus.evicted = rsp_ev_ff;
   assign rsp_bus.evicted_handle = rsp_eh_ff;
   assign rsp_bus.last = rsp_last_ff;

endmodule

@@ hw/rtl/rovc_checker.sv @@
module rovc_checker
   import rovc_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   rsp_status,
   input logic                         rsp_evicted,
   input logic                         rsp_last,
   input logic [FIELD_HANDLE_BITS-1:0] rsp_found_handle
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
      else $error("rsp beat dropped while stalled");

   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_CLEARED |-> rsp_last)
      else $error("single-beat reply without last");

   a_evict_ins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_status == ST_INSERTED)
      else $error("eviction on a non-insert reply");

   a_fh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HIT && rsp_status != ST_CLEARED |-> rsp_found_handle == '0)
      else $error("stray found handle");

endmodule

bind released_object_victim_cache_unit rovc_checker u_rovc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_evicted      (rsp_bus.evicted),
   .rsp_last         (rsp_bus.last),
   .rsp_found_handle (rsp_bus.found_handle)
);

@@ tb/tb_rovc_model.sv @@
module tb;
   import rovc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;
   localparam int HEAD  = SLOTS;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_handle;
      logic        evicted;
      logic [31:0] evicted_handle;
      logic        last;
   } result_t;

   typedef struct {
      func_type    func;
      logic [63:0] key;
      logic [31:0] handle;
      bit          typed;
      status_type  status;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rovc_req_if req_bus ();
   rovc_rsp_if rsp_bus ();
   rovc_csr_if csr_bus ();

   released_object_victim_cache_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache shadow
   int          nxt [SLOTS+1];
   int          prv [SLOTS+1];
   logic [63:0] skey [SLOTS];
   logic [31:0] shdl [SLOTS];
   bit          used [SLOTS];
   int          freelist [SLOTS];
   int          free_top;
   int          count;
   int          cap;

   result_t     expected_results [$];
   logic [63:0] live_keys [$];
   int          errors = 0;
   int          results_seen = 0;
   int          hits = 0;
   int          evictions = 0;
   int          clears = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          hold_rsp = 1'b0;

   function automatic void wipe_cache();
      for (int i = 0; i < SLOTS; i++) begin
         nxt[i] = 0;
         prv[i] = 0;
         skey[i] = '0;
         shdl[i] = '0;
         used[i] = 1'b0;
         freelist[i] = i;
      end
      nxt[HEAD] = HEAD;
      prv[HEAD] = HEAD;
      free_top = SLOTS;
      count = 0;
   endfunction

   function automatic void take_out(int s);
      int n, p;
      n = nxt[s];
      p = prv[s];
      nxt[p] = n;
      prv[n] = p;
      used[s] = 1'b0;
      if (free_top < SLOTS) begin
         freelist[free_top] = s;
         free_top++;
      end
      if (count > 0) count--;
   endfunction

   function automatic int slot_of(logic [63:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (used[i] && skey[i] == k) return i;
      return -1;
   endfunction

   function automatic result_t mk(status_type st, logic [31:0] fh, logic ev,
                                  logic [31:0] eh, logic lst);
      result_t r;
      r.status = st;
      r.found_handle = fh;
      r.evicted = ev;
      r.evicted_handle = eh;
      r.last = lst;
      return r;
   endfunction

   function automatic void expect_beat(result_t r);
      expected_results = {expected_results, r};
   endfunction

   function automatic void predict_cache(func_type f, logic [63:0] k, logic [31:0] h);
      logic        ev;
      logic [31:0] eh;
      int          s, tail, idx, nx;
      ev = 1'b0;
      eh = '0;
      case (f)
         FUNC_INSERT: begin
            if (k == 0 || cap == 0) begin
               expect_beat(mk(ST_REFUSED, 0, 0, 0, 1));
            end else if (slot_of(k) >= 0) begin
               expect_beat(mk(ST_DUPLICATE, 0, 0, 0, 1));
            end else begin
               if (count >= cap && nxt[HEAD] != HEAD) begin
                  ev = 1'b1;
                  eh = shdl[nxt[HEAD]];
                  take_out(nxt[HEAD]);
                  evictions++;
               end
               if (free_top == 0) begin
                  expect_beat(mk(ST_REFUSED, 0, ev, eh, 1));
               end else begin
                  free_top--;
                  s = freelist[free_top];
                  tail = prv[HEAD];
                  prv[s] = tail;
                  nxt[s] = HEAD;
                  nxt[tail] = s;
                  prv[HEAD] = s;
                  skey[s] = k;
                  shdl[s] = h;
                  used[s] = 1'b1;
                  count++;
                  expect_beat(mk(ST_INSERTED, 0, ev, eh, 1));
               end
            end
         end
         FUNC_LOOKUP: begin
            s = slot_of(k);
            if (k == 0 || s < 0) begin
               expect_beat(mk(ST_MISS, 0, 0, 0, 1));
            end else begin
               expect_beat(mk(ST_HIT, shdl[s], 0, 0, 1));
               take_out(s);
               hits++;
            end
         end
         FUNC_CLEAR: begin
            clears++;
            idx = nxt[HEAD];
            if (idx == HEAD) begin
               expect_beat(mk(ST_EMPTY, 0, 0, 0, 1));
            end else begin
               while (idx != HEAD) begin
                  nx = nxt[idx];
                  expect_beat(mk(ST_CLEARED, shdl[idx], 0, 0, nx == HEAD));
                  idx = nx;
               end
            end
            wipe_cache();
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %0t %s got %0h want %0h", $time, what, got, want);
      errors++;
   endtask

   // rsp side
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected beat status", rsp_bus.status, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.found_handle !== want.found_handle)
               report_mismatch("found_handle", rsp_bus.found_handle, want.found_handle);
            if (rsp_bus.evicted !== want.evicted)
               report_mismatch("evicted", rsp_bus.evicted, want.evicted);
            if (rsp_bus.evicted_handle !== want.evicted_handle)
               report_mismatch("evicted_handle", rsp_bus.evicted_handle,
                               want.evicted_handle);
            if (rsp_bus.last !== want.last)
               report_mismatch("last", rsp_bus.last, want.last);
         end
      end
   end

   task automatic send_req(func_type f, logic [63:0] k, logic [31:0] h);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= f;
      req_bus.key <= k;
      req_bus.handle <= h;
      do @(posedge clock); while (!req_bus.ready);
      predict_cache(f, k, h);
      if (f == FUNC_INSERT && k != 0) live_keys = {live_keys, k};
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] v);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      cap = (v > SLOTS) ? SLOTS : v;
      wipe_cache();
      live_keys.delete();
   endtask

   function automatic logic [63:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 55 && live_keys.size() != 0)
         return live_keys[$urandom_range(live_keys.size() - 1)];
      if (r < 85) return 64'($urandom_range(40, 1));
      return {$urandom, $urandom};
   endfunction

   task automatic random_items(int n);
      int       r;
      func_type f;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         f = r < 55 ? FUNC_INSERT : r < 92 ? FUNC_LOOKUP : r < 97 ? FUNC_CLEAR : FUNC_NONE;
         send_req(f, pick_key(), $urandom);
      end
   endtask

   row_t rows [$];

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_NONE;
      req_bus.key = '0;
      req_bus.handle = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      cap = SLOTS;
      wipe_cache();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      rows = '{
         '{FUNC_CLEAR,  64'd0, 32'd0, 1, ST_EMPTY},
         '{FUNC_LOOKUP, 64'd5, 32'd0, 1, ST_MISS},
         '{FUNC_INSERT, 64'd0, 32'h1, 1, ST_REFUSED},
         '{FUNC_INSERT, '1, '1, 1, ST_INSERTED},
         '{FUNC_INSERT, '1, 32'h7, 1, ST_DUPLICATE},
         '{FUNC_LOOKUP, 64'd0, 32'd0, 1, ST_MISS},
         '{FUNC_INSERT, 64'd1, 32'd0, 1, ST_INSERTED},
         '{FUNC_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1, ST_INSERTED},
         '{FUNC_NONE,   64'd9, 32'd9, 0, ST_UNUSED},
         '{FUNC_LOOKUP, '1, 32'd0, 1, ST_HIT},
         '{FUNC_LOOKUP, '1, 32'd0, 1, ST_MISS},
         '{FUNC_CLEAR,  64'd0, 32'd0, 1, ST_CLEARED}
      };
      foreach (rows[i]) begin
         send_req(rows[i].func, rows[i].key, rows[i].handle);
         if (rows[i].typed && expected_results.size() != 0 &&
             expected_results[expected_results.size()-1].status != rows[i].status)
            report_mismatch("directed row status",
                            expected_results[expected_results.size()-1].status,
                            rows[i].status);
      end
      for (int i = 1; i <= 18; i++) send_req(FUNC_INSERT, 64'(100 + i), 32'(i));
      send_req(FUNC_CLEAR, 0, 0);

      write_capacity(5'd0);
      send_req(FUNC_INSERT, 64'd3, 32'd3);
      write_capacity(5'd31);
      for (int i = 1; i <= 17; i++) send_req(FUNC_INSERT, 64'(200 + i), 32'(i));

      // long hold-off: block fills, input stalls
      fork
         begin
            hold_rsp = 1'b1;
            for (int c = 0; c < 300; c++) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_items(20);
      join

      for (int ph = 0; ph < 4; ph++) begin
         req_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 62 : 27) : 0;
         rsp_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 62 : 27) : 0;
         write_capacity(ph == 0 ? 5'd1 : ph == 1 ? 5'd4 : ph == 2 ? 5'd16 : 5'd9);
         random_items(90);
      end
      drain();
      $display("covered %0d beats, %0d hits, %0d evictions, %0d clears", results_seen,
               hits, evictions, clears);
      $display("capacities 0, 1, 4, 9, 16 and saturated; four idle/stall mixes");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
